// ===== rtl/hufd_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the Huffman tree decoder.
`timescale 1ns / 1ps

package hufd_pkg;

    // Default size of the node store
    localparam int NODE_COUNT_DEF = 512;

    // Longest code that a load walks; longer lengths are cut to this
    localparam int MAX_CODE_LEN = 32;

    // Field widths
    localparam int OP_W     = 2;
    localparam int SYM_W    = 8;
    localparam int LEN_W    = 6;
    localparam int CODE_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;

    // Bits consumed by one decode item
    localparam int BYTE_BITS = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
    localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr;        // write the root as a lone node, reset the node count and decode position
        logic ld_start;   // capture a load item
        logic ld_read;    // follow an existing child during a load
        logic ld_take;    // take the children of the node just read
        logic ld_link;    // allocate a new child and link it to its parent
        logic ld_init;    // write the new node as empty
        logic ld_sym;     // write the symbol into the final node
        logic ld_full;    // report a full node store
        logic dec_start;  // capture a decode item and read the position node
        logic dec_take;   // take the children of the position node
        logic dec_read;   // read the child that the current bit selects
        logic dec_miss;   // report a missing branch and go back to the root
        logic dec_eval;   // test the child for a leaf and move on
        logic flush;      // hand the held result on as the last one of the item
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic ld_done;        // all code bits walked
        logic ld_child_zero;  // the selected child slot is empty
        logic ld_full;        // no free node left
        logic dec_done;       // all bits of the byte consumed
        logic dec_next_zero;  // the selected child is absent
        logic dec_leaf;       // the node just read has no children
        logic pend_v;         // a result is held back
        logic out_free;       // the output register can take a result
    } t_stat;

endpackage

// ===== rtl/hufd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module hufd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/hufd_datapath.sv =====
// Datapath of the Huffman tree decoder: node memories, walk registers and result buffering.
`timescale 1ns / 1ps

module hufd_datapath #(
    parameter int NODE_COUNT = hufd_pkg::NODE_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hufd_pkg::t_cmd                 i_cmd,
    output hufd_pkg::t_stat                o_stat,
    input  logic [hufd_pkg::SYM_W-1:0]     i_code_symbol,
    input  logic [hufd_pkg::LEN_W-1:0]     i_code_len,
    input  logic [hufd_pkg::CODE_W-1:0]    i_code_bits,
    input  logic [hufd_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [hufd_pkg::SYM_W-1:0]     o_symbol,
    output logic [hufd_pkg::STATUS_W-1:0]  o_status,
    output logic                           o_last
);

    import hufd_pkg::*;

    localparam int NW = $clog2(NODE_COUNT);
    localparam int CW = $clog2(BYTE_BITS + 1);
    localparam logic [NW:0] NodeMax = (NW + 1)'(NODE_COUNT);
    localparam logic [LEN_W-1:0] LenMax = LEN_W'(MAX_CODE_LEN);
    localparam logic [LEN_W-1:0] CodeWidth = LEN_W'(CODE_W);

    // Walk registers
    logic [NW-1:0]       r_root_l, r_root_r;
    logic [NW-1:0]       r_cur_l, r_cur_r;
    logic [NW-1:0]       r_node;
    logic [NW-1:0]       r_dec_node;
    logic [NW-1:0]       r_dec_next;
    logic [NW:0]         r_nodes_used;
    logic [LEN_W-1:0]    r_rem;
    logic [CODE_W-1:0]   r_bits;
    logic [SYM_W-1:0]    r_symbol;
    logic [BYTE_W-1:0]   r_byte;
    logic [CW-1:0]       r_bitcnt;

    // Result buffering
    logic                r_pend_v;
    logic [SYM_W-1:0]    r_pend_sym;
    logic [STATUS_W-1:0] r_pend_status;
    logic                r_out_v;
    logic [SYM_W-1:0]    r_out_sym;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_last;

    // Memory ports
    logic                rd_en;
    logic [NW-1:0]       rd_addr;
    logic [NW-1:0]       wr_addr;
    logic                left_we, right_we, sym_we;
    logic [NW-1:0]       child_wdata;
    logic [SYM_W-1:0]    sym_wdata;
    logic [NW-1:0]       rd_left, rd_right;
    logic [SYM_W-1:0]    rd_sym;

    // Derived values
    logic [LEN_W-1:0]    ld_pos;
    logic                ld_bit;
    logic [NW-1:0]       ld_child;
    logic [NW-1:0]       dec_next;
    logic                dec_leaf;
    logic                out_free;
    logic                emit;
    logic [SYM_W-1:0]    emit_sym;
    logic [STATUS_W-1:0] emit_status;
    logic [LEN_W-1:0]    len_clamped;

    // Current load bit: positions at and above the code width read as zero
    assign ld_pos   = r_rem - LEN_W'(1);
    assign ld_bit   = (ld_pos < CodeWidth) ? r_bits[ld_pos[$clog2(CODE_W)-1:0]] : 1'b0;
    assign ld_child = ld_bit ? r_cur_r : r_cur_l;

    // Current decode bit is the top of the shifting byte
    assign dec_next = r_byte[BYTE_W-1] ? r_cur_r : r_cur_l;
    assign dec_leaf = (rd_left == '0) && (rd_right == '0);

    assign len_clamped = (i_code_len > LenMax) ? LenMax : i_code_len;

    assign out_free = !r_out_v || i_ready;

    // Result produced in this cycle
    always_comb begin
        emit        = 1'b0;
        emit_sym    = '0;
        emit_status = ST_OK;
        if (i_cmd.ld_full) begin
            emit        = 1'b1;
            emit_status = ST_FULL;
        end else if (i_cmd.dec_miss) begin
            emit        = 1'b1;
            emit_status = ST_MISSING;
        end else if (i_cmd.dec_eval && dec_leaf) begin
            emit        = 1'b1;
            emit_sym    = rd_sym;
            emit_status = ST_OK;
        end
    end

    // Memory port selection
    always_comb begin
        rd_en   = i_cmd.dec_start || i_cmd.dec_read || i_cmd.ld_read;
        rd_addr = ld_child;
        if (i_cmd.dec_start) begin
            rd_addr = r_dec_node;
        end else if (i_cmd.dec_read) begin
            rd_addr = dec_next;
        end
        wr_addr     = i_cmd.clr ? '0 : r_node;
        left_we     = i_cmd.clr || i_cmd.ld_init || (i_cmd.ld_link && !ld_bit);
        right_we    = i_cmd.clr || i_cmd.ld_init || (i_cmd.ld_link && ld_bit);
        child_wdata = i_cmd.ld_link ? r_nodes_used[NW-1:0] : '0;
        sym_we      = i_cmd.clr || i_cmd.ld_init || i_cmd.ld_sym;
        sym_wdata   = i_cmd.ld_sym ? r_symbol : '0;
    end

    hufd_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (left_we),
        .i_waddr (wr_addr),
        .i_wdata (child_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_left)
    );

    hufd_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (right_we),
        .i_waddr (wr_addr),
        .i_wdata (child_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_right)
    );

    hufd_ram #(.WIDTH(SYM_W), .DEPTH(NODE_COUNT)) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (sym_we),
        .i_waddr (wr_addr),
        .i_wdata (sym_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_sym)
    );

    // Tree bookkeeping and the decode position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes_used <= (NW + 1)'(1);
            r_dec_node   <= '0;
            r_root_l     <= '0;
            r_root_r     <= '0;
        end else if (i_cmd.clr) begin
            r_nodes_used <= (NW + 1)'(1);
            r_dec_node   <= '0;
            r_root_l     <= '0;
            r_root_r     <= '0;
        end else begin
            if (i_cmd.ld_link) begin
                r_nodes_used <= r_nodes_used + (NW + 1)'(1);
                if (r_node == '0) begin
                    if (ld_bit) begin
                        r_root_r <= r_nodes_used[NW-1:0];
                    end else begin
                        r_root_l <= r_nodes_used[NW-1:0];
                    end
                end
            end
            if (i_cmd.dec_miss || (i_cmd.dec_eval && dec_leaf)) begin
                r_dec_node <= '0;
            end else if (i_cmd.dec_eval) begin
                r_dec_node <= r_dec_next;
            end
        end
    end

    // Walk registers for load and decode items
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_start) begin
            r_symbol <= i_code_symbol;
            r_bits   <= i_code_bits;
            r_rem    <= len_clamped;
            r_node   <= '0;
            r_cur_l  <= r_root_l;
            r_cur_r  <= r_root_r;
        end
        if (i_cmd.ld_read) begin
            r_node <= ld_child;
            r_rem  <= ld_pos;
        end
        if (i_cmd.ld_link) begin
            r_node  <= r_nodes_used[NW-1:0];
            r_rem   <= ld_pos;
            r_cur_l <= '0;
            r_cur_r <= '0;
        end
        if (i_cmd.ld_take || i_cmd.dec_take) begin
            r_cur_l <= rd_left;
            r_cur_r <= rd_right;
        end
        if (i_cmd.dec_start) begin
            r_byte   <= i_data_byte;
            r_bitcnt <= CW'(BYTE_BITS);
        end
        if (i_cmd.dec_read) begin
            r_dec_next <= dec_next;
        end
        if (i_cmd.dec_miss || (i_cmd.dec_eval && dec_leaf)) begin
            r_cur_l <= r_root_l;
            r_cur_r <= r_root_r;
        end else if (i_cmd.dec_eval) begin
            r_cur_l <= rd_left;
            r_cur_r <= rd_right;
        end
        if (i_cmd.dec_miss || i_cmd.dec_eval) begin
            r_byte   <= {r_byte[BYTE_W-2:0], 1'b0};
            r_bitcnt <= r_bitcnt - CW'(1);
        end
    end

    // Result buffering: one result is held back until it is known whether it is the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.flush) begin
                r_out_v      <= 1'b1;
                r_out_sym    <= r_pend_sym;
                r_out_status <= r_pend_status;
                r_out_last   <= 1'b1;
                r_pend_v     <= 1'b0;
            end else if (emit) begin
                if (r_pend_v) begin
                    r_out_v      <= 1'b1;
                    r_out_sym    <= r_pend_sym;
                    r_out_status <= r_pend_status;
                    r_out_last   <= 1'b0;
                end else if (r_out_v && i_ready) begin
                    r_out_v <= 1'b0;
                end
                r_pend_v      <= 1'b1;
                r_pend_sym    <= emit_sym;
                r_pend_status <= emit_status;
            end else if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_v;
    assign o_symbol = r_out_sym;
    assign o_status = r_out_status;
    assign o_last   = r_out_last;

    // Status towards the controller
    always_comb begin
        o_stat               = '0;
        o_stat.ld_done       = (r_rem == '0);
        o_stat.ld_child_zero = (ld_child == '0);
        o_stat.ld_full       = (r_nodes_used >= NodeMax);
        o_stat.dec_done      = (r_bitcnt == '0);
        o_stat.dec_next_zero = (dec_next == '0);
        o_stat.dec_leaf      = dec_leaf;
        o_stat.pend_v        = r_pend_v;
        o_stat.out_free      = out_free;
    end

    // A held result is only displaced when the output register can take it
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_pend_v) |-> out_free)
        else $error("result displaced while the output register is full");

    // The node count stays between one and the store size
    a_nodes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nodes_used != '0) && (r_nodes_used <= NodeMax))
        else $error("node count out of range");

    // After a flush nothing is held back
    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> !r_pend_v)
        else $error("result still held after flush");

endmodule

// ===== rtl/hufd_ctrl.sv =====
// Controller state machine of the Huffman tree decoder.
`timescale 1ns / 1ps

module hufd_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [hufd_pkg::OP_W-1:0]    i_op,
    output logic                         o_ready,
    output hufd_pkg::t_cmd               o_cmd,
    input  hufd_pkg::t_stat              i_stat
);

    import hufd_pkg::*;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_LD_STEP  = 4'd2;
    localparam logic [3:0] S_LD_TAKE  = 4'd3;
    localparam logic [3:0] S_LD_INIT  = 4'd4;
    localparam logic [3:0] S_LD_SYM   = 4'd5;
    localparam logic [3:0] S_DEC_TAKE = 4'd6;
    localparam logic [3:0] S_DEC_STEP = 4'd7;
    localparam logic [3:0] S_DEC_EVAL = 4'd8;
    localparam logic [3:0] S_FLUSH    = 4'd9;

    logic [3:0] r_state, n_state;
    logic       accept;
    logic       can_emit;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign can_emit = !i_stat.pend_v || i_stat.out_free;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_CLEAR: begin
                            n_state = S_CLEAR;
                        end
                        OP_LOAD: begin
                            o_cmd.ld_start = 1'b1;
                            n_state        = S_LD_STEP;
                        end
                        OP_DECODE: begin
                            o_cmd.dec_start = 1'b1;
                            n_state         = S_DEC_TAKE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_LD_STEP: begin
                if (i_stat.ld_done) begin
                    n_state = S_LD_SYM;
                end else if (i_stat.ld_child_zero) begin
                    if (i_stat.ld_full) begin
                        o_cmd.ld_full = 1'b1;
                        n_state       = S_FLUSH;
                    end else begin
                        o_cmd.ld_link = 1'b1;
                        n_state       = S_LD_INIT;
                    end
                end else begin
                    o_cmd.ld_read = 1'b1;
                    n_state       = S_LD_TAKE;
                end
            end
            S_LD_TAKE: begin
                o_cmd.ld_take = 1'b1;
                n_state       = S_LD_STEP;
            end
            S_LD_INIT: begin
                o_cmd.ld_init = 1'b1;
                n_state       = S_LD_STEP;
            end
            S_LD_SYM: begin
                o_cmd.ld_sym = 1'b1;
                n_state      = S_IDLE;
            end
            S_DEC_TAKE: begin
                o_cmd.dec_take = 1'b1;
                n_state        = S_DEC_STEP;
            end
            S_DEC_STEP: begin
                if (i_stat.dec_done) begin
                    n_state = S_FLUSH;
                end else if (i_stat.dec_next_zero) begin
                    if (can_emit) begin
                        o_cmd.dec_miss = 1'b1;
                    end
                end else begin
                    o_cmd.dec_read = 1'b1;
                    n_state        = S_DEC_EVAL;
                end
            end
            S_DEC_EVAL: begin
                if (!i_stat.dec_leaf || can_emit) begin
                    o_cmd.dec_eval = 1'b1;
                    n_state        = S_DEC_STEP;
                end
            end
            S_FLUSH: begin
                if (!i_stat.pend_v) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register; reset writes the root first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // A new child is always written as an empty node in the next cycle
    a_link_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld_link |=> o_cmd.ld_init)
        else $error("allocated node not initialised");

    // A decode child read is always followed by its evaluation state
    a_read_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.dec_read |=> (r_state == S_DEC_EVAL))
        else $error("decode read without evaluation");

    // The last result of an item is only handed on when the output register is free
    a_flush_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.flush |-> i_stat.out_free)
        else $error("flush while the output register is full");

endmodule

// ===== rtl/huffman_tree_decoder_core.sv =====
// Top level of the Huffman tree decoder: controller and datapath.
//
// Input channel (i_valid / o_ready) takes one item: op 0 clears the tree to a
// lone root, op 1 loads one code (symbol, length, right-aligned bits), op 2
// decodes one byte MSB first, op 3 is ignored. Output channel (o_valid /
// i_ready) carries results: a symbol, a status (decoded, missing branch,
// node store full) and a last flag on the final result of each item.
// One item is in work at a time; o_ready is high only while the block idles.
// Each code bit of a load goes through the registered read or the
// allocate-and-initialise pair of the node memory. A decode reads the node
// memory for each bit that follows a child; a bit that hits a missing branch
// needs no read. The decode position carries over between bytes.
// Each result is held back one step so that its last flag is known, then
// passes through an output register; while that register is full and a
// further result is due, the walk waits. After reset the block writes the
// root node before it raises o_ready.
`timescale 1ns / 1ps

module huffman_tree_decoder_core #(
    parameter int NODE_COUNT = hufd_pkg::NODE_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [hufd_pkg::OP_W-1:0]      i_op,
    input  logic [hufd_pkg::SYM_W-1:0]     i_code_symbol,
    input  logic [hufd_pkg::LEN_W-1:0]     i_code_len,
    input  logic [hufd_pkg::CODE_W-1:0]    i_code_bits,
    input  logic [hufd_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [hufd_pkg::SYM_W-1:0]     o_symbol,
    output logic [hufd_pkg::STATUS_W-1:0]  o_status,
    output logic                           o_last
);

    import hufd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencing of each item
    hufd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_ready (o_ready),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    // Node memories, walk registers and result registers
    hufd_datapath #(.NODE_COUNT(NODE_COUNT)) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_code_symbol (i_code_symbol),
        .i_code_len    (i_code_len),
        .i_code_bits   (i_code_bits),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_symbol      (o_symbol),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule

// ===== sim/huffman_tree_decoder_core_tb.sv =====
// Self-checking testbench for the Huffman tree decoder: directed table, code sets and noise.
`timescale 1ns / 1ps

module huffman_tree_decoder_core_tb;
    import hufd_pkg::*;

    localparam int NODES       = NODE_COUNT_DEF;
    localparam int NODE_W      = $clog2(NODES);
    localparam int IDLE_PCT    = 21;
    localparam int RAND_ITEMS  = 120;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;

    // The one op code that the block ignores
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef logic [NODE_W-1:0] t_node;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
        logic [BYTE_W-1:0] data;
    } t_item;

    typedef struct packed {
        logic [SYM_W-1:0]    sym;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_res;

    // One row of the directed table; typed rows carry their results in the row
    typedef struct packed {
        t_item               it;
        bit                  typed;
        logic [3:0]          n_res;
        logic [STATUS_W-1:0] status;
        logic [SYM_W-1:0]    sym;
    } t_dir_row;

    // Clock, reset and block inputs, all known from time zero
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                i_ready = 1'b0;
    logic [OP_W-1:0]     i_op = OP_UNUSED;
    logic [SYM_W-1:0]    i_code_symbol = '0;
    logic [LEN_W-1:0]    i_code_len = '0;
    logic [CODE_W-1:0]   i_code_bits = '0;
    logic [BYTE_W-1:0]   i_data_byte = '0;
    logic                o_ready;
    logic                o_valid;
    logic [SYM_W-1:0]    o_symbol;
    logic [STATUS_W-1:0] o_status;
    logic                o_last;

    // Shadow copy of the code tree
    t_node            tr_left  [NODES];
    t_node            tr_right [NODES];
    logic [SYM_W-1:0] tr_sym   [NODES];
    int unsigned      tr_used = 1;
    t_node            tr_pos = '0;
    bit               store_full_seen = 1'b0;

    t_res     walk_out[$];
    t_res     due_symbols[$];
    t_dir_row dir_rows[$];
    t_res     got_want;

    bit no_idle = 1'b0;
    int fails = 0;
    int cycles = 0;
    int items_sent = 0;
    int n_clear = 0, n_load = 0, n_decode = 0;
    int n_ok = 0, n_miss = 0, n_full = 0;

    huffman_tree_decoder_core #(
        .NODE_COUNT(NODES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_code_symbol (i_code_symbol),
        .i_code_len    (i_code_len),
        .i_code_bits   (i_code_bits),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_symbol      (o_symbol),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Run limit: anything that hangs ends here
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side stalls at random, except during the calm stretch
    always @(posedge i_clk) begin
        i_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Results are sampled mid-cycle and taken at the following edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (o_status == ST_OK) n_ok++;
            else if (o_status == ST_MISSING) n_miss++;
            else if (o_status == ST_FULL) n_full++;
            if (due_symbols.size() == 0) begin
                $error("unexpected result: symbol %0h status %0d last %0b",
                       o_symbol, o_status, o_last);
                fails++;
            end else begin
                got_want = due_symbols.pop_front();
                if (o_symbol !== got_want.sym) begin
                    $error("symbol mismatch: expected %0h, got %0h", got_want.sym, o_symbol);
                    fails++;
                end
                if (o_status !== got_want.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           got_want.status, o_status);
                    fails++;
                end
                if (o_last !== got_want.last) begin
                    $error("last mismatch: expected %0b, got %0b", got_want.last, o_last);
                    fails++;
                end
            end
        end
    end

    // Applies one item to the shadow tree and leaves its results in walk_out.
    function automatic void walk_tree(input t_item it);
        int unsigned len;
        int          i;
        int          b;
        t_node       cur;
        t_node       nxt;
        logic        dir;
        bit          stop;
        t_res        r;
        walk_out.delete();
        case (it.op)
            OP_CLEAR: begin
                tr_left[0]  = '0;
                tr_right[0] = '0;
                tr_sym[0]   = '0;
                tr_used     = 1;
                tr_pos      = '0;
            end
            OP_LOAD: begin
                // Lengths past the longest code are cut back
                len  = (it.len > MAX_CODE_LEN) ? MAX_CODE_LEN : it.len;
                cur  = '0;
                stop = 1'b0;
                for (i = 0; i < len; i++) begin
                    if (!stop) begin
                        dir = it.code[len - 1 - i];
                        nxt = dir ? tr_right[cur] : tr_left[cur];
                        if (nxt == '0) begin
                            if (tr_used >= NODES) begin
                                // Store exhausted: nodes already made stay, no symbol
                                r.sym    = '0;
                                r.status = ST_FULL;
                                r.last   = 1'b1;
                                walk_out.push_back(r);
                                store_full_seen = 1'b1;
                                stop = 1'b1;
                            end else begin
                                nxt = t_node'(tr_used);
                                tr_left[nxt]  = '0;
                                tr_right[nxt] = '0;
                                tr_sym[nxt]   = '0;
                                if (dir) tr_right[cur] = nxt;
                                else tr_left[cur] = nxt;
                                tr_used++;
                            end
                        end
                        if (!stop) cur = nxt;
                    end
                end
                if (!stop) tr_sym[cur] = it.sym;
            end
            OP_DECODE: begin
                // One step per bit, MSB first; a leaf or a dead end returns to the root
                for (b = BYTE_BITS - 1; b >= 0; b--) begin
                    dir = it.data[b];
                    nxt = dir ? tr_right[tr_pos] : tr_left[tr_pos];
                    if (nxt == '0) begin
                        r.sym    = '0;
                        r.status = ST_MISSING;
                        r.last   = 1'b0;
                        walk_out.push_back(r);
                        tr_pos = '0;
                    end else if (tr_left[nxt] == '0 && tr_right[nxt] == '0) begin
                        r.sym    = tr_sym[nxt];
                        r.status = ST_OK;
                        r.last   = 1'b0;
                        walk_out.push_back(r);
                        tr_pos = '0;
                    end else begin
                        tr_pos = nxt;
                    end
                end
                if (walk_out.size() > 0) begin
                    r = walk_out.pop_back();
                    r.last = 1'b1;
                    walk_out.push_back(r);
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void put_row(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                    input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code,
                                    input logic [BYTE_W-1:0] data, input bit typed,
                                    input logic [3:0] n_res,
                                    input logic [STATUS_W-1:0] status,
                                    input logic [SYM_W-1:0] rsym);
        t_dir_row row;
        row.it.op   = op;
        row.it.sym  = sym;
        row.it.len  = len;
        row.it.code = code;
        row.it.data = data;
        row.typed   = typed;
        row.n_res   = n_res;
        row.status  = status;
        row.sym     = rsym;
        dir_rows.push_back(row);
    endfunction

    function automatic t_item random_item();
        t_item it;
        it.op   = OP_W'($urandom_range(0, 3));
        it.sym  = SYM_W'($urandom);
        it.len  = LEN_W'($urandom);
        it.code = $urandom;
        it.data = BYTE_W'($urandom);
        return it;
    endfunction

    // Presents one item after an optional gap and returns once it is taken.
    task automatic present(input t_item it);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= it.op;
        i_code_symbol <= it.sym;
        i_code_len    <= it.len;
        i_code_bits   <= it.code;
        i_data_byte   <= it.data;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        if (it.op == OP_CLEAR) n_clear++;
        else if (it.op == OP_LOAD) n_load++;
        else if (it.op == OP_DECODE) n_decode++;
        if (it.op != OP_UNUSED) items_sent++;
    endtask

    // Predicts an item's results, queues them, then sends the item.
    task automatic issue(input t_item it);
        walk_tree(it);
        foreach (walk_out[k]) due_symbols.push_back(walk_out[k]);
        present(it);
    endtask

    // Holds the input side until every queued result has arrived.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (due_symbols.size() != 0) @(posedge i_clk);
    endtask

    // Loads random 32-bit codes until the node store runs out, then checks
    // that an existing path still loads and that the full tree decodes.
    task automatic fill_store();
        t_item       it;
        logic [31:0] first_code;
        int          i;
        it = random_item();
        it.op = OP_CLEAR;
        issue(it);
        store_full_seen = 1'b0;
        first_code = $urandom;
        it.code = first_code;
        while (!store_full_seen) begin
            it.op  = OP_LOAD;
            it.sym = SYM_W'($urandom);
            it.len = LEN_W'(MAX_CODE_LEN);
            issue(it);
            it.code = $urandom;
        end
        it.op   = OP_LOAD;
        it.code = first_code;
        it.sym  = SYM_W'($urandom);
        issue(it);
        for (i = 0; i < 4; i++) begin
            it.op   = OP_DECODE;
            it.data = BYTE_W'($urandom);
            issue(it);
        end
    endtask

    // Builds a prefix code, loads it into a cleared tree and decodes random
    // bytes. Sometimes a code is dropped or noise slips in among the loads.
    task automatic run_code_set();
        logic [CODE_W-1:0] leaf_code[$];
        int                leaf_len[$];
        logic [CODE_W-1:0] c;
        bit                deep;
        int                want;
        int                idx;
        int                tries;
        int                i;
        t_item             it;
        deep = ($urandom_range(0, 5) == 0);
        want = deep ? $urandom_range(10, 33) : $urandom_range(2, 16);
        leaf_code.push_back('0);
        leaf_len.push_back(0);
        tries = 0;
        // A deep set keeps splitting its newest leaf, giving one long chain
        while (leaf_code.size() < want && tries < 200) begin
            idx = deep ? leaf_code.size() - 1 : $urandom_range(0, leaf_code.size() - 1);
            if (leaf_len[idx] < (deep ? MAX_CODE_LEN : 8)) begin
                c = leaf_code[idx];
                leaf_code[idx] = c << 1;
                leaf_len[idx]  = leaf_len[idx] + 1;
                leaf_code.push_back((c << 1) | 1);
                leaf_len.push_back(leaf_len[idx]);
            end
            tries++;
        end
        it = random_item();
        it.op = OP_CLEAR;
        issue(it);
        if ($urandom_range(0, 6) == 0) begin
            idx = $urandom_range(0, leaf_code.size() - 1);
            leaf_code.delete(idx);
            leaf_len.delete(idx);
        end
        // Load in random order; bits above the code length are junk
        while (leaf_code.size() > 0) begin
            idx = $urandom_range(0, leaf_code.size() - 1);
            it.op   = OP_LOAD;
            it.sym  = SYM_W'($urandom);
            it.len  = LEN_W'(leaf_len[idx]);
            it.code = leaf_code[idx] | ($urandom << leaf_len[idx]);
            it.data = BYTE_W'($urandom);
            issue(it);
            leaf_code.delete(idx);
            leaf_len.delete(idx);
            if ($urandom_range(0, 9) == 0) issue(random_item());
        end
        want = $urandom_range(2, 8);
        for (i = 0; i < want; i++) begin
            it = random_item();
            it.op = OP_DECODE;
            issue(it);
        end
    endtask

    initial begin
        int base;
        int scen;
        int pick;
        int k;
        t_res r;

        tr_left[0]  = '0;
        tr_right[0] = '0;
        tr_sym[0]   = '0;

        // Directed table: op, symbol, length, code, byte, typed, count, status, symbol
        // Empty tree: every bit hits a missing branch
        put_row(OP_DECODE, 8'h00, 6'd0, 32'h0, 8'h00, 1, 4'd8, ST_MISSING, 8'h00);
        put_row(OP_UNUSED, 8'hFF, 6'd63, 32'hFFFF_FFFF, 8'hFF, 1, 4'd0, ST_OK, 8'h00);
        // Zero-length code names the root, which is never emitted
        put_row(OP_LOAD, 8'hA5, 6'd0, 32'h0, 8'h00, 1, 4'd0, ST_OK, 8'h00);
        put_row(OP_DECODE, 8'h00, 6'd0, 32'h0, 8'hFF, 1, 4'd8, ST_MISSING, 8'h00);
        put_row(OP_LOAD, 8'h00, 6'd1, 32'h0, 8'h00, 1, 4'd0, ST_OK, 8'h00);
        put_row(OP_LOAD, 8'hFF, 6'd1, 32'hFFFF_FFFF, 8'h00, 1, 4'd0, ST_OK, 8'h00);
        put_row(OP_DECODE, 8'h00, 6'd0, 32'h0, 8'h55, 0, 4'd0, ST_OK, 8'h00);
        put_row(OP_CLEAR, 8'h00, 6'd0, 32'h0, 8'h00, 1, 4'd0, ST_OK, 8'h00);
        put_row(OP_LOAD, 8'h11, 6'd2, 32'h2, 8'h00, 1, 4'd0, ST_OK, 8'h00);
        put_row(OP_LOAD, 8'h22, 6'd2, 32'h3, 8'h00, 1, 4'd0, ST_OK, 8'h00);
        put_row(OP_LOAD, 8'h33, 6'd1, 32'h0, 8'h00, 1, 4'd0, ST_OK, 8'h00);
        put_row(OP_DECODE, 8'h00, 6'd0, 32'h0, 8'hE0, 0, 4'd0, ST_OK, 8'h00);
        // A code split across two bytes
        put_row(OP_DECODE, 8'h00, 6'd0, 32'h0, 8'h01, 0, 4'd0, ST_OK, 8'h00);
        put_row(OP_DECODE, 8'h00, 6'd0, 32'h0, 8'h80, 0, 4'd0, ST_OK, 8'h00);
        put_row(OP_CLEAR, 8'h00, 6'd0, 32'h0, 8'h00, 1, 4'd0, ST_OK, 8'h00);
        put_row(OP_LOAD, 8'h77, 6'd3, 32'h5, 8'h00, 1, 4'd0, ST_OK, 8'h00);
        put_row(OP_DECODE, 8'h00, 6'd0, 32'h0, 8'hA0, 0, 4'd0, ST_OK, 8'h00);
        // Symbol written onto an inner node is kept but not emitted
        put_row(OP_LOAD, 8'h99, 6'd2, 32'h2, 8'h00, 1, 4'd0, ST_OK, 8'h00);
        put_row(OP_DECODE, 8'h00, 6'd0, 32'h0, 8'hA0, 0, 4'd0, ST_OK, 8'h00);
        put_row(OP_LOAD, 8'h5A, 6'd3, 32'h4, 8'h00, 1, 4'd0, ST_OK, 8'h00);
        put_row(OP_DECODE, 8'h00, 6'd0, 32'h0, 8'h80, 0, 4'd0, ST_OK, 8'h00);
        // Over-long length is cut to the longest code; the walk then yields nothing
        put_row(OP_LOAD, 8'hC3, 6'd63, 32'hFFFF_FFFF, 8'h00, 1, 4'd0, ST_OK, 8'h00);
        put_row(OP_DECODE, 8'h00, 6'd0, 32'h0, 8'hFF, 1, 4'd0, ST_OK, 8'h00);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part
        foreach (dir_rows[j]) begin
            if (dir_rows[j].typed) begin
                walk_tree(dir_rows[j].it);
                for (k = 0; k < dir_rows[j].n_res; k++) begin
                    r.sym    = dir_rows[j].sym;
                    r.status = dir_rows[j].status;
                    r.last   = (k == dir_rows[j].n_res - 1);
                    due_symbols.push_back(r);
                end
                present(dir_rows[j].it);
            end else begin
                issue(dir_rows[j].it);
            end
        end
        fill_store();
        drain_results();

        // Random part: mostly well-formed code sets, some noise, rare refills
        base = items_sent;
        scen = 0;
        while (items_sent - base < RAND_ITEMS) begin
            no_idle <= (scen >= 5 && scen < 11);
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                run_code_set();
            end else if (pick < 19) begin
                for (k = 0; k < 6; k++) issue(random_item());
            end else begin
                fill_store();
            end
            if ($urandom_range(0, 4) == 0) drain_results();
            scen++;
        end
        no_idle <= 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d items: %0d clears, %0d code loads, %0d bytes, in %0d cycles.",
                 items_sent, n_clear, n_load, n_decode, cycles);
        $display("Results seen: %0d symbols, %0d missing branches, %0d store-full reports.",
                 n_ok, n_miss, n_full);
        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
